>>> sv/idac_pkg.sv
// Shared constants, command codes and memory control bundles for the
// incremental DDT APN checker. No dependencies.
package idac_pkg;

  // Default S-box word width in bits.
  localparam int unsigned BitsDefault = 7;

  // Width of the position and value fields of an input item.
  localparam int unsigned FieldW = 7;

  // A halved difference count is two bits wide and saturates at three.
  localparam int unsigned CntW = 2;
  localparam logic [CntW-1:0] CntMax = CntW'(3);
  localparam logic [CntW-1:0] CntOnePair = CntW'(1);

  // Command codes.
  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  // Control bundle for the S-box store.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } sbox_ctl_t;

  // Control bundle for the difference count memory.
  typedef struct packed {
    logic rd;
    logic wr;
  } cnt_ctl_t;

endpackage

>>> sv/idac_sbox.sv
// Partial S-box store: a value memory with registered read data plus one
// valid flop per entry. Depends on idac_pkg.
module idac_sbox #(
  parameter int unsigned BITS = idac_pkg::BitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  idac_pkg::sbox_ctl_t   ctl_i,
  input  logic [BITS-1:0]       rd_addr_i,
  input  logic [BITS-1:0]       wr_addr_i,
  input  logic [BITS-1:0]       wr_data_i,
  output logic [BITS-1:0]       rd_data_o,
  output logic                  rd_valid_o
);

  localparam int unsigned Depth = 1 << BITS;

  logic [BITS-1:0] mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [BITS-1:0] rd_data_q;
  logic rd_valid_q;

  // Value memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Valid bits: all entries are undefined after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (ctl_i.clr) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
      if (ctl_i.rd) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

>>> sv/idac_cnt_ram.sv
// Difference count memory: a single-write, single-read synchronous RAM of
// halved DDT entries with registered read data. Depends on idac_pkg.
module idac_cnt_ram #(
  parameter int unsigned BITS = idac_pkg::BitsDefault
) (
  input  logic                        clk_i,
  input  idac_pkg::cnt_ctl_t          ctl_i,
  input  logic [2*BITS-1:0]           rd_addr_i,
  input  logic [2*BITS-1:0]           wr_addr_i,
  input  logic [idac_pkg::CntW-1:0]   wr_data_i,
  output logic [idac_pkg::CntW-1:0]   rd_data_o
);

  localparam int unsigned Depth = 1 << (2 * BITS);

  logic [idac_pkg::CntW-1:0] mem [Depth];
  logic [idac_pkg::CntW-1:0] rd_data_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/idac_walk.sv
// Command sequencer: clears the count memory after reset, then walks the
// even-weight differences of each item through a three-stage read-modify-write
// pipeline over the S-box store and the count memory. Depends on idac_pkg.
module idac_walk #(
  parameter int unsigned BITS = idac_pkg::BitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [idac_pkg::FieldW-1:0]   position_i,
  input  logic [idac_pkg::FieldW-1:0]   value_i,
  output logic                          done_o,
  output logic                          still_apn_o,
  output idac_pkg::sbox_ctl_t           sbox_ctl_o,
  output logic [BITS-1:0]               sbox_rd_addr_o,
  output logic [BITS-1:0]               sbox_wr_addr_o,
  output logic [BITS-1:0]               sbox_wr_data_o,
  input  logic [BITS-1:0]               sbox_rd_data_i,
  input  logic                          sbox_rd_valid_i,
  output idac_pkg::cnt_ctl_t            cnt_ctl_o,
  output logic [2*BITS-1:0]             cnt_rd_addr_o,
  output logic [2*BITS-1:0]             cnt_wr_addr_o,
  output logic [idac_pkg::CntW-1:0]     cnt_wr_data_o,
  input  logic [idac_pkg::CntW-1:0]     cnt_rd_data_i
);

  localparam int unsigned KW = BITS - 1;
  localparam int unsigned AW = 2 * BITS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_WALK
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  idac_pkg::cmd_e cmd_q, cmd_d;
  logic [BITS-1:0] x_q, x_d;
  logic [BITS-1:0] y_q, y_d;
  logic [KW-1:0] k_q, k_d;
  logic issue_q, issue_d;
  logic s1_vld_q, s1_vld_d;
  logic [BITS-1:0] s1_a_q, s1_a_d;
  logic s2_vld_q, s2_vld_d;
  logic [AW-1:0] s2_idx_q, s2_idx_d;
  logic done_q, done_d;
  logic apn_q, apn_d;

  logic accept;
  logic [BITS-1:0] pos_x;
  logic [BITS-1:0] a_cur;
  logic [idac_pkg::CntW-1:0] cnt_new;
  logic stop_now;
  logic drained;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign pos_x  = BITS'(position_i);

  // The k-th even-weight difference is k followed by its parity bit, which
  // lists them in ascending order.
  assign a_cur = {k_q, ^k_q};

  // Saturating update of the count read back in the last stage.
  always_comb begin
    if (cmd_q == idac_pkg::CMD_ADD) begin
      cnt_new = (cnt_rd_data_i == idac_pkg::CntMax) ? idac_pkg::CntMax
                                                    : cnt_rd_data_i + idac_pkg::CntW'(1);
      stop_now = s2_vld_q && (cnt_new > idac_pkg::CntOnePair);
    end else begin
      cnt_new = (cnt_rd_data_i == '0) ? '0 : cnt_rd_data_i - idac_pkg::CntW'(1);
      stop_now = s2_vld_q && (cnt_new == idac_pkg::CntOnePair);
    end
  end

  assign drained = !issue_q && !s1_vld_q && !s2_vld_q;

  // Next-state logic and memory port control.
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    cmd_d      = cmd_q;
    x_d        = x_q;
    y_d        = y_q;
    k_d        = k_q;
    issue_d    = issue_q;
    s1_vld_d   = 1'b0;
    s1_a_d     = s1_a_q;
    s2_vld_d   = 1'b0;
    s2_idx_d   = s2_idx_q;
    done_d     = 1'b0;
    apn_d      = apn_q;

    sbox_ctl_o     = '0;
    sbox_rd_addr_o = x_q ^ a_cur;
    sbox_wr_addr_o = x_q;
    sbox_wr_data_o = y_q;
    cnt_ctl_o      = '0;
    cnt_rd_addr_o  = s2_idx_q;
    cnt_wr_addr_o  = s2_idx_q;
    cnt_wr_data_o  = cnt_new;

    case (state_q)
      // Zero the count memory one entry a cycle.
      ST_CLEAR: begin
        cnt_ctl_o.wr  = 1'b1;
        cnt_wr_addr_o = clr_addr_q;
        cnt_wr_data_o = '0;
        clr_addr_d    = clr_addr_q + AW'(1);
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      // Take an item: an add writes its point at once, a remove reads it.
      ST_IDLE: begin
        sbox_rd_addr_o = pos_x;
        sbox_wr_addr_o = pos_x;
        sbox_wr_data_o = BITS'(value_i);
        if (accept) begin
          cmd_d = idac_pkg::cmd_e'(command_i);
          x_d   = pos_x;
          y_d   = BITS'(value_i);
          k_d   = KW'(1);
          if (idac_pkg::cmd_e'(command_i) == idac_pkg::CMD_ADD) begin
            sbox_ctl_o.wr = 1'b1;
            issue_d       = 1'b1;
            state_d       = ST_WALK;
          end else begin
            sbox_ctl_o.rd = 1'b1;
            state_d       = ST_LOAD;
          end
        end
      end

      // A remove picks up the stored value; an undefined point ends at once.
      ST_LOAD: begin
        y_d = sbox_rd_data_i;
        if (sbox_rd_valid_i) begin
          issue_d = 1'b1;
          state_d = ST_WALK;
        end else begin
          done_d  = 1'b1;
          apn_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end

      // Three stages: S-box read, count read, count update and write back.
      // Each stage works on a different difference, so the count indexes
      // in flight never collide.
      ST_WALK: begin
        sbox_ctl_o.rd = issue_q;
        if (issue_q) begin
          s1_vld_d = 1'b1;
          s1_a_d   = a_cur;
          k_d      = k_q + KW'(1);
          if (k_q == '1) begin
            issue_d = 1'b0;
          end
        end
        s2_vld_d      = s1_vld_q && sbox_rd_valid_i;
        s2_idx_d      = {s1_a_q, y_q ^ sbox_rd_data_i};
        cnt_rd_addr_o = s2_idx_d;
        cnt_ctl_o.rd  = s2_vld_d;
        cnt_ctl_o.wr  = s2_vld_q;
        if (stop_now || drained) begin
          issue_d  = 1'b0;
          s1_vld_d = 1'b0;
          s2_vld_d = 1'b0;
          done_d   = 1'b1;
          apn_d    = !(stop_now && (cmd_q == idac_pkg::CMD_ADD));
          sbox_ctl_o.clr = (cmd_q == idac_pkg::CMD_REMOVE);
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      cmd_q      <= idac_pkg::CMD_ADD;
      x_q        <= '0;
      y_q        <= '0;
      k_q        <= '0;
      issue_q    <= 1'b0;
      s1_vld_q   <= 1'b0;
      s1_a_q     <= '0;
      s2_vld_q   <= 1'b0;
      s2_idx_q   <= '0;
      done_q     <= 1'b0;
      apn_q      <= 1'b1;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      cmd_q      <= cmd_d;
      x_q        <= x_d;
      y_q        <= y_d;
      k_q        <= k_d;
      issue_q    <= issue_d;
      s1_vld_q   <= s1_vld_d;
      s1_a_q     <= s1_a_d;
      s2_vld_q   <= s2_vld_d;
      s2_idx_q   <= s2_idx_d;
      done_q     <= done_d;
      apn_q      <= apn_d;
    end
  end

  assign done_o      = done_q;
  assign still_apn_o = apn_q;

  // A count update only follows a valid S-box stage in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> $past(s1_vld_q))
    else $error("count stage valid without a preceding S-box stage");

  // The count memory is written only while clearing or walking.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ctl_o.wr |-> (state_q == ST_CLEAR || state_q == ST_WALK))
    else $error("count memory written outside clear or walk");

  // A remove always reports success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && cmd_q == idac_pkg::CMD_REMOVE) |-> apn_q)
    else $error("remove reported a failure");

  // A result is given only once the pipeline holds nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!issue_q && !s1_vld_q && !s2_vld_q && state_q == ST_IDLE))
    else $error("result given while the walk is still in flight");

endmodule

>>> sv/incremental_ddt_apn_check.sv
// Top level of the incremental DDT APN checker: the sequencer, the partial
// S-box store and the difference count memory. Depends on idac_pkg.
//
//  Channel   Handshake            Signals
//  --------  -------------------  ------------------------------------
//  item in   start && !busy       command_i, position_i, value_i
//  result    done_o (one cycle)   still_apn_o
//
// After reset the count memory is cleared one entry a cycle with busy high.
// An item walks the 2^(BITS-1) - 1 even-weight differences through one S-box
// read and one count read-modify-write a cycle; a remove first reads its
// stored value. A remove at an undefined point keeps busy high for one
// cycle, an add that fails ends early. done_o rises in the cycle busy
// falls; the receiver takes it without stalling.
module incremental_ddt_apn_check #(
  parameter int unsigned BITS = idac_pkg::BitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [idac_pkg::FieldW-1:0]   position_i,
  input  logic [idac_pkg::FieldW-1:0]   value_i,
  output logic                          done_o,
  output logic                          still_apn_o
);

  idac_pkg::sbox_ctl_t sbox_ctl;
  logic [BITS-1:0] sbox_rd_addr;
  logic [BITS-1:0] sbox_wr_addr;
  logic [BITS-1:0] sbox_wr_data;
  logic [BITS-1:0] sbox_rd_data;
  logic sbox_rd_valid;

  idac_pkg::cnt_ctl_t cnt_ctl;
  logic [2*BITS-1:0] cnt_rd_addr;
  logic [2*BITS-1:0] cnt_wr_addr;
  logic [idac_pkg::CntW-1:0] cnt_wr_data;
  logic [idac_pkg::CntW-1:0] cnt_rd_data;

  // Sequencer and update pipeline.
  idac_walk #(
    .BITS(BITS)
  ) u_walk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .still_apn_o     (still_apn_o),
    .sbox_ctl_o      (sbox_ctl),
    .sbox_rd_addr_o  (sbox_rd_addr),
    .sbox_wr_addr_o  (sbox_wr_addr),
    .sbox_wr_data_o  (sbox_wr_data),
    .sbox_rd_data_i  (sbox_rd_data),
    .sbox_rd_valid_i (sbox_rd_valid),
    .cnt_ctl_o       (cnt_ctl),
    .cnt_rd_addr_o   (cnt_rd_addr),
    .cnt_wr_addr_o   (cnt_wr_addr),
    .cnt_wr_data_o   (cnt_wr_data),
    .cnt_rd_data_i   (cnt_rd_data)
  );

  // Partial S-box with valid bits.
  idac_sbox #(
    .BITS(BITS)
  ) u_sbox (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sbox_ctl),
    .rd_addr_i  (sbox_rd_addr),
    .wr_addr_i  (sbox_wr_addr),
    .wr_data_i  (sbox_wr_data),
    .rd_data_o  (sbox_rd_data),
    .rd_valid_o (sbox_rd_valid)
  );

  // Halved difference counts.
  idac_cnt_ram #(
    .BITS(BITS)
  ) u_cnt_ram (
    .clk_i     (clk_i),
    .ctl_i     (cnt_ctl),
    .rd_addr_i (cnt_rd_addr),
    .wr_addr_i (cnt_wr_addr),
    .wr_data_i (cnt_wr_data),
    .rd_data_o (cnt_rd_data)
  );

endmodule
